>>> rtl/core/aes256_pkg.sv
// ---------------------------------------------------------------------------
// AES-256 package
// Types, constants and byte functions shared by the encryption pipeline.
// ---------------------------------------------------------------------------
package aes256_pkg;

  localparam int DataW   = 64;
  localparam int BlockW  = 128;
  localparam int KeyW    = 256;
  localparam int NumRegs = 4;
  localparam int CfgIdxW = 2;
  localparam int NumRounds = 14;
  localparam int DefaultRounds = NumRounds;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [KeyW-1:0]   key_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_255_192 = 2'd0,
    REG_KEY_191_128 = 2'd1,
    REG_KEY_127_64  = 2'd2,
    REG_KEY_63_0    = 2'd3
  } cfg_reg_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [8] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte n of a block sits in bits 127-8n down to 120-8n.
  function automatic logic [7:0] blk_byte(input block_t s, input int n);
    blk_byte = s[BlockW-1-8*n -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(4*c+r) -: 8] = SBOX[blk_byte(s, 4*((c+r)%4)+r)];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t mix_cols(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = blk_byte(s, 4*c);
      a1 = blk_byte(s, 4*c+1);
      a2 = blk_byte(s, 4*c+2);
      a3 = blk_byte(s, 4*c+3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[BlockW-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[BlockW-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[BlockW-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[BlockW-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_cols = t;
  endfunction

endpackage

>>> rtl/core/aes256_if.sv
// ---------------------------------------------------------------------------
// AES-256 stream interface
// Valid/ready channel carrying one 128-bit block as two 64-bit halves.
// ---------------------------------------------------------------------------
interface aes256_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;

  modport source (output valid, output data_high, output data_low, input ready);
  modport sink (input valid, input data_high, input data_low, output ready);
endinterface

>>> rtl/core/aes256_block_encrypt_top.sv
// ---------------------------------------------------------------------------
// AES-256 block encryption top level
// Fully pipelined AES-256 encryptor with a chain of round cells.
// ---------------------------------------------------------------------------
// One plaintext request is accepted every cycle unless the chain is stalled.
// Its ciphertext passes an input register holding the initial key addition,
// then fourteen round cells, each computing one round and one key schedule step.
// The whole chain advances together and stalls only when the output is full
// and not being taken. The key registers must only be written while the
// pipeline is empty.
module aes256_block_encrypt_top #(
  parameter int Rounds = aes256_pkg::DefaultRounds
) (
  input  logic                            clk,
  input  logic                            rst_n,
  aes256_if.sink                          in_ch,
  aes256_if.source                        out_ch,
  input  logic                            cfg_we,
  input  logic [aes256_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [aes256_pkg::DataW-1:0]    cfg_wdata
);
  import aes256_pkg::*;

  logic [DataW-1:0] key_r [NumRegs];
  key_t             key_all;
  logic             en;
  logic             vld [Rounds+1];
  block_t           st  [Rounds+1];
  key_t             kw  [Rounds+1];
  logic             vld0_r;
  block_t           st0_r;
  key_t             kw0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) key_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_KEY_255_192: key_r[0] <= cfg_wdata;
        REG_KEY_191_128: key_r[1] <= cfg_wdata;
        REG_KEY_127_64:  key_r[2] <= cfg_wdata;
        REG_KEY_63_0:    key_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign key_all = {key_r[0], key_r[1], key_r[2], key_r[3]};

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st0_r <= {in_ch.data_high, in_ch.data_low} ^ key_all[KeyW-1 -: BlockW];
      kw0_r <= key_all;
    end
  end

  assign vld[0] = vld0_r;
  assign st[0]  = st0_r;
  assign kw[0]  = kw0_r;

  for (genvar g = 1; g <= Rounds; g++) begin : g_round
    aes256_round_cell #(.Round(g), .Rounds(Rounds)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (vld[g-1]),
      .st_in   (st[g-1]),
      .key_in  (kw[g-1]),
      .vld_out (vld[g]),
      .st_out  (st[g]),
      .key_out (kw[g])
    );
  end

  assign out_ch.valid     = vld[Rounds];
  assign out_ch.data_high = st[Rounds][BlockW-1 -: DataW];
  assign out_ch.data_low  = st[Rounds][DataW-1:0];

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data_high))
    else $error("result changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && out_ch.ready |=> vld[0])
    else $error("accepted request lost at pipeline entry");
endmodule

>>> rtl/core/aes256_round_cell.sv
// ---------------------------------------------------------------------------
// AES-256 round cell
// One round of the cipher plus one step of the key schedule, registered.
// The cell receives the state and an eight-word key window from its left
// neighbor and hands the state and the window shifted by four words to the
// right.
// ---------------------------------------------------------------------------
module aes256_round_cell #(
  parameter int Round  = 1,
  parameter int Rounds = aes256_pkg::DefaultRounds
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_in,
  input  aes256_pkg::block_t  st_in,
  input  aes256_pkg::key_t    key_in,
  output logic                vld_out,
  output aes256_pkg::block_t  st_out,
  output aes256_pkg::key_t    key_out
);
  import aes256_pkg::*;

  logic        vld_r;
  block_t      st_r, st_nxt;
  key_t        key_r, key_nxt;
  logic [31:0] t, w0, w1, w2, w3;
  block_t      rk;
  block_t      s1;

  // The round key of this round is the lower half of the incoming window.
  // Every cell appends the next four schedule words and drops the oldest four.
  always_comb begin
    rk = key_in[BlockW-1:0];
    s1 = sub_shift(st_in);
    if (Round < Rounds) begin
      s1 = mix_cols(s1);
    end
    st_nxt = s1 ^ rk;
    t = key_in[31:0];
    if (Round % 2 == 1) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {RCON[((Round + 1) / 2) % 8], 24'h0};
    end else begin
      t = sub_word(t);
    end
    w0 = key_in[KeyW-1 -: 32] ^ t;
    w1 = key_in[KeyW-33 -: 32] ^ w0;
    w2 = key_in[KeyW-65 -: 32] ^ w1;
    w3 = key_in[KeyW-97 -: 32] ^ w2;
    key_nxt = {key_in[BlockW-1:0], w0, w1, w2, w3};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r  <= st_nxt;
      key_r <= key_nxt;
    end
  end

  assign vld_out = vld_r;
  assign st_out  = st_r;
  assign key_out = key_r;
endmodule

>>> dv/aes256_block_encrypt_top_test.sv
// ---------------------------------------------------------------------------
// AES-256 block encryption testbench
// Sends plaintext requests under several keys with random gaps and stalls and
// checks every ciphertext against an AES-256 predictor kept in the bench.
// ---------------------------------------------------------------------------
module aes256_block_encrypt_top_test;
  import aes256_pkg::*;

  class cipher_board;
    logic [255:0] key;
    block_t pending[$];
    int errors;

    function block_t shifted_sub(block_t s);
      block_t t;
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[127-8*(4*c+r) -: 8] = SBOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
      return t;
    endfunction

    function logic [7:0] dbl(logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function block_t mixed(block_t s);
      block_t t;
      logic [7:0] a[4];
      logic [7:0] x;
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) a[r] = s[127-8*(4*c+r) -: 8];
        x = a[0] ^ a[1] ^ a[2] ^ a[3];
        for (int r = 0; r < 4; r++)
          t[127-8*(4*c+r) -: 8] = a[r] ^ x ^ dbl(a[r] ^ a[(r+1)%4]);
      end
      return t;
    endfunction

    function logic [31:0] sbox_word(logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function block_t encrypt(block_t p);
      logic [31:0] w[60];
      logic [31:0] t;
      block_t s;
      for (int i = 0; i < 8; i++) w[i] = key[255-32*i -: 32];
      for (int i = 8; i < 60; i++) begin
        t = w[i-1];
        if (i % 8 == 0) t = sbox_word({t[23:0], t[31:24]}) ^ {RCON[i/8], 24'h0};
        else if (i % 8 == 4) t = sbox_word(t);
        w[i] = w[i-8] ^ t;
      end
      s = p ^ {w[0], w[1], w[2], w[3]};
      for (int r = 1; r <= 14; r++) begin
        s = shifted_sub(s);
        if (r < 14) s = mixed(s);
        s = s ^ {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
      end
      return s;
    endfunction

    function void note_plain(block_t p);
      pending.push_back(encrypt(p));
    endfunction

    function void check_cipher(block_t c);
      block_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected ciphertext %h", $time, c);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e[127:64] !== c[127:64]) begin
        $display("%0t: cipher_high expected %h actual %h", $time, e[127:64], c[127:64]);
        errors++;
      end
      if (e[63:0] !== c[63:0]) begin
        $display("%0t: cipher_low expected %h actual %h", $time, e[63:0], c[63:0]);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [DataW-1:0] cfg_wdata;
  aes256_if in_ch();
  aes256_if out_ch();
  cipher_board board;
  bit long_hold;
  bit sending_done;

  aes256_block_encrypt_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    if (idx == REG_KEY_255_192) board.key[255:192] = v;
    else if (idx == REG_KEY_191_128) board.key[191:128] = v;
    else if (idx == REG_KEY_127_64) board.key[127:64] = v;
    else board.key[63:0] = v;
  endtask

  task automatic load_key(logic [255:0] k);
    write_reg(REG_KEY_255_192, k[255:192]);
    write_reg(REG_KEY_191_128, k[191:128]);
    write_reg(REG_KEY_127_64, k[127:64]);
    write_reg(REG_KEY_63_0, k[63:0]);
    cfg_we <= 1'b0;
  endtask

  task automatic send_plain(block_t p, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_high <= p[127:64];
    in_ch.data_low <= p[63:0];
    do @(posedge clk); while (!in_ch.ready);
    board.note_plain(p);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic run_phase(logic [255:0] k, int count);
    block_t p;
    load_key(k);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0: p = '0;
        1: p = '1;
        default: p = {rand64(), rand64()};
      endcase
      send_plain(p, $urandom_range(0, 3) != 0);
    end
    drain();
  endtask

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) out_ch.ready <= 1'b0;
      else if (sending_done) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk)
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_cipher({out_ch.data_high, out_ch.data_low});

  initial begin
    board = new();
    board.key = '0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_KEY_255_192;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data_high = '0;
    in_ch.data_low = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Zero key before any write, then the standard FIPS-197 vector.
    send_plain('0, 0);
    send_plain('1, 0);
    drain();
    load_key(256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f);
    send_plain(128'h00112233445566778899aabbccddeeff, 0);
    for (int b = 0; b < 16; b++) send_plain(128'h1 << (8 * b + b % 8), 0);
    send_plain({64'h8000000000000000, 64'h1}, 0);
    drain();

    // Back-to-back requests against a long receiver stall.
    fork
      begin
        long_hold = 1'b1;
        repeat (60) @(negedge clk);
        long_hold = 1'b0;
      end
      for (int i = 0; i < 40; i++) send_plain({rand64(), rand64()}, 0);
    join
    drain();

    run_phase('1, 150);
    run_phase({rand64(), rand64(), rand64(), rand64()}, 300);
    run_phase({64'h8000000000000000, 192'h0}, 100);
    run_phase({rand64(), rand64(), rand64(), rand64()}, 300);
    run_phase({192'h0, 64'h1}, 100);
    run_phase({rand64(), rand64(), rand64(), rand64()}, 120);
    sending_done = 1'b1;
    drain();
    if (board.errors == 0 && board.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
